>>> src/matrix_axis_reduction_macros.svh
// assertion macros for the matrix axis reduction block
// expects i_clk and i_rst_n in the scope of use
`ifndef MATRIX_AXIS_REDUCTION_MACROS_SVH
`define MATRIX_AXIS_REDUCTION_MACROS_SVH

// consequent checked in the same cycle
`define MAR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define MAR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/mar_pkg.sv
// shared types, codes and limits of the matrix axis reduction block
// no dependencies
package mar_pkg;

    localparam int MAX_COLUMNS_DEF = 64;
    localparam int MAX_ROWS        = 1024;
    localparam logic [10:0] ROW_LIM = (MAX_ROWS < 1024) ? 11'(MAX_ROWS) : 11'd1024;

    localparam int ACC_W  = 48;
    localparam int ELEM_W = 32;
    localparam int ROW_W  = 10;
    localparam int COL_W  = 6;
    localparam int CFG_W  = 11;

    typedef enum logic [1:0] {
        OP_SUM = 2'd0,
        OP_MAX = 2'd1,
        OP_MIN = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        AXIS_ROW = 2'd0,
        AXIS_COL = 2'd1,
        AXIS_ALL = 2'd2
    } t_axis;

    typedef enum logic [1:0] {
        REG_OPERATION    = 2'd0,
        REG_REDUCE_AXIS  = 2'd1,
        REG_ROW_COUNT    = 2'd2,
        REG_COLUMN_COUNT = 2'd3
    } t_reg;

    typedef enum logic [1:0] {
        ST_RUN,
        ST_DRN_RD,
        ST_DRN_WT
    } t_state;

    typedef struct packed {
        logic signed [ACC_W-1:0] x;
        logic                    seed;
        logic [1:0]              axis;
        logic [1:0]              op;
        logic [COL_W-1:0]        col;
        logic [ROW_W-1:0]        row;
        logic                    mat_end;
        logic                    has_res;
    } t_s1;

endpackage

>>> src/matrix_axis_reduction.sv
// top level of the matrix axis reduction block
// depends on mar_pkg, mar_ram, mar_combine and the assertion macro header
//
// usage:
// - configuration: write operation, reduce_axis, row_count and column_count
//   through i_cfg_wr_en / i_cfg_index / i_cfg_data while the block is idle
// - input channel: i_in_valid with i_element, the block drives o_in_stall;
//   one transaction carries one Q16.16 element, matrix in row-major order
// - output channel: o_out_valid with o_reduced_value, o_result_index and
//   o_last_result, the receiver drives i_out_stall
// - one element per cycle is taken while the output is not stalled and no readout runs
// - a row or whole-matrix result passes through the element stage, then the output register
// - per-column mode keeps its accumulators in a ram; after the last element
//   the ram is read out column by column, each column by one ram read and then
//   one output load, with no input taken until the last column has been loaded
//   into the output register
// - a stalled output holds its transaction; the element stage behind it
//   holds too once it has a result waiting, and then input is stalled
// - reset clears the position counters, the accumulator and all valids;
//   the ram needs no clearing
`include "matrix_axis_reduction_macros.svh"

module matrix_axis_reduction
    import mar_pkg::*;
#(
    parameter int MAX_COLUMNS = MAX_COLUMNS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_wr_en,
    input  logic [1:0]              i_cfg_index,
    input  logic [CFG_W-1:0]        i_cfg_data,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic signed [ELEM_W-1:0] i_element,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic signed [ACC_W-1:0] o_reduced_value,
    output logic [ROW_W-1:0]        o_result_index,
    output logic                    o_last_result
);

    localparam int CW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam logic [COL_W:0] COL_LIM = (COL_W+1)'(MAX_COLUMNS);

    // configuration
    logic [1:0]         r_operation;
    logic [1:0]         r_axis;
    logic [10:0]        r_row_count;
    logic [COL_W:0]     r_column_count;

    // positions and running accumulator
    logic [ROW_W-1:0]        r_row_pos;
    logic [COL_W-1:0]        r_col_pos;
    logic signed [ACC_W-1:0] r_acc;

    // element stage
    t_s1  r_s1;
    logic r_s1_vld;

    // drain control
    t_state           r_state;
    t_state           n_state;
    logic [COL_W-1:0] r_drn_col;

    // forwarding of a write that lands on the entry being read
    logic                    r_fwd_hit;
    logic signed [ACC_W-1:0] r_fwd_data;

    // output register
    logic                    r_out_vld;
    logic signed [ACC_W-1:0] r_out_value;
    logic [ROW_W-1:0]        r_out_index;
    logic                    r_out_last;

    logic [10:0]             rows_raw;
    logic [10:0]             eff_rows;
    logic [COL_W:0]          cols_raw;
    logic [COL_W:0]          eff_cols;
    logic                    row_end;
    logic                    mat_end;
    logic                    in_acc;
    logic                    out_free;
    logic                    s1_fire;
    logic                    drn_last;
    logic                    drn_load;
    logic                    s1_load;
    logic signed [ACC_W-1:0] x_ext;
    t_s1                     s1_new;
    logic signed [ACC_W-1:0] acc_src;
    logic signed [ACC_W-1:0] comb_res;
    logic signed [ACC_W-1:0] ram_rdata;
    logic signed [ACC_W-1:0] rd_data;
    logic                    ram_we;
    logic                    ram_re;
    logic [CW-1:0]           ram_waddr;
    logic [CW-1:0]           ram_raddr;

    // effective counts
    assign rows_raw = (r_row_count == '0) ? 11'd1 : r_row_count;
    assign eff_rows = (rows_raw > ROW_LIM) ? ROW_LIM : rows_raw;
    assign cols_raw = (r_column_count == '0) ? (COL_W+1)'(1) : r_column_count;
    assign eff_cols = (cols_raw > COL_LIM) ? COL_LIM : cols_raw;

    assign row_end = ({1'b0, r_col_pos} + (COL_W+1)'(1)) >= eff_cols;
    assign mat_end = row_end && (({1'b0, r_row_pos} + 11'd1) >= eff_rows);

    assign x_ext = {{(ACC_W-ELEM_W){i_element[ELEM_W-1]}}, i_element};

    // handshakes
    assign out_free   = !r_out_vld || !i_out_stall;
    assign s1_fire    = r_s1_vld && (!r_s1.has_res || out_free);
    assign o_in_stall = (r_state != ST_RUN) || (r_s1_vld && !s1_fire);
    assign in_acc     = i_in_valid && !o_in_stall;

    // element stage contents
    always_comb begin
        s1_new         = '0;
        s1_new.x       = x_ext;
        s1_new.axis    = r_axis;
        s1_new.op      = r_operation;
        s1_new.col     = r_col_pos;
        s1_new.row     = r_row_pos;
        s1_new.mat_end = mat_end;
        case (r_axis)
            AXIS_ROW: begin
                s1_new.seed    = (r_col_pos == '0);
                s1_new.has_res = row_end;
            end
            AXIS_COL: begin
                s1_new.seed    = (r_row_pos == '0);
                s1_new.has_res = 1'b0;
            end
            default: begin
                s1_new.seed    = (r_row_pos == '0) && (r_col_pos == '0);
                s1_new.has_res = mat_end;
            end
        endcase
    end

    // column accumulator ram
    assign ram_we    = s1_fire && (r_s1.axis == AXIS_COL);
    assign ram_waddr = r_s1.col[CW-1:0];
    assign ram_re    = (in_acc && (r_axis == AXIS_COL)) || (r_state == ST_DRN_RD);
    assign ram_raddr = (r_state == ST_DRN_RD) ? r_drn_col[CW-1:0] : r_col_pos[CW-1:0];

    mar_ram #(
        .WIDTH (ACC_W),
        .DEPTH (MAX_COLUMNS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (comb_res),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd_data = r_fwd_hit ? r_fwd_data : ram_rdata;
    assign acc_src = (r_s1.axis == AXIS_COL) ? rd_data : r_acc;

    mar_combine u_combine (
        .i_op   (r_s1.op),
        .i_seed (r_s1.seed),
        .i_acc  (acc_src),
        .i_x    (r_s1.x),
        .o_res  (comb_res)
    );

    assign drn_last = ({1'b0, r_drn_col} + (COL_W+1)'(1)) >= eff_cols;
    assign drn_load = (r_state == ST_DRN_WT) && out_free;
    assign s1_load  = s1_fire && r_s1.has_res;

    // drain sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_RUN: begin
                if (in_acc && (r_axis == AXIS_COL) && mat_end) begin
                    n_state = ST_DRN_RD;
                end
            end
            ST_DRN_RD: n_state = ST_DRN_WT;
            ST_DRN_WT: begin
                if (out_free) begin
                    n_state = drn_last ? ST_RUN : ST_DRN_RD;
                end
            end
            default: n_state = ST_RUN;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_RUN;
        end else begin
            r_state <= n_state;
        end
    end

    // configuration and control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_operation    <= OP_SUM;
            r_axis         <= AXIS_ALL;
            r_row_count    <= 11'd1;
            r_column_count <= (COL_W+1)'(1);
            r_row_pos      <= '0;
            r_col_pos      <= '0;
            r_acc          <= '0;
            r_s1_vld       <= 1'b0;
            r_drn_col      <= '0;
            r_fwd_hit      <= 1'b0;
            r_out_vld      <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    REG_OPERATION:    r_operation    <= i_cfg_data[1:0];
                    REG_REDUCE_AXIS:  r_axis         <= i_cfg_data[1:0];
                    REG_ROW_COUNT:    r_row_count    <= i_cfg_data;
                    REG_COLUMN_COUNT: r_column_count <= i_cfg_data[COL_W:0];
                    default: ;
                endcase
            end

            if (in_acc) begin
                if (mat_end) begin
                    r_row_pos <= '0;
                    r_col_pos <= '0;
                end else if (row_end) begin
                    r_col_pos <= '0;
                    r_row_pos <= r_row_pos + ROW_W'(1);
                end else begin
                    r_col_pos <= r_col_pos + COL_W'(1);
                end
            end

            if (in_acc) begin
                r_s1_vld <= 1'b1;
            end else if (s1_fire) begin
                r_s1_vld <= 1'b0;
            end

            if (s1_fire && (r_s1.axis != AXIS_COL)) begin
                r_acc <= comb_res;
            end

            if (ram_re) begin
                r_fwd_hit <= ram_we && (ram_waddr == ram_raddr);
            end

            if (drn_load) begin
                r_drn_col <= drn_last ? '0 : r_drn_col + COL_W'(1);
            end

            if (s1_load || drn_load) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1 <= s1_new;
        end
        if (ram_re) begin
            r_fwd_data <= comb_res;
        end
        if (s1_load) begin
            r_out_value <= comb_res;
            r_out_index <= (r_s1.axis == AXIS_ROW) ? r_s1.row : '0;
            r_out_last  <= (r_s1.axis == AXIS_ROW) ? r_s1.mat_end : 1'b1;
        end else if (drn_load) begin
            r_out_value <= rd_data;
            r_out_index <= ROW_W'(r_drn_col);
            r_out_last  <= drn_last;
        end
    end

    assign o_out_valid     = r_out_vld;
    assign o_reduced_value = r_out_value;
    assign o_result_index  = r_out_index;
    assign o_last_result   = r_out_last;

    `MAR_ASSERT_NEXT(a_drain_starts, in_acc && (r_axis == AXIS_COL) && mat_end,
        r_state == ST_DRN_RD, "column matrix end did not start the readout")
    `MAR_ASSERT_NOW(a_drain_stage_empty, r_state == ST_DRN_WT, !r_s1_vld,
        "element stage busy during readout")
    `MAR_ASSERT_NOW(a_col_no_result, r_s1_vld && (r_s1.axis == AXIS_COL), !r_s1.has_res,
        "column element carries a result")
    `MAR_ASSERT_NEXT(a_drain_last, drn_load && drn_last, o_out_valid && o_last_result,
        "final column not marked last")

endmodule

>>> src/mar_ram.sv
// generic single-port-write, single-port-read ram with registered read
// read data holds while no read is issued; no dependencies
module mar_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/mar_combine.sv
// combine unit: seeds or folds one element into an accumulator
// depends on mar_pkg
module mar_combine
    import mar_pkg::*;
(
    input  logic [1:0]              i_op,
    input  logic                    i_seed,
    input  logic signed [ACC_W-1:0] i_acc,
    input  logic signed [ACC_W-1:0] i_x,
    output logic signed [ACC_W-1:0] o_res
);

    always_comb begin
        if (i_seed) begin
            o_res = i_x;
        end else begin
            case (i_op)
                OP_MAX:  o_res = (i_x > i_acc) ? i_x : i_acc;
                OP_MIN:  o_res = (i_x < i_acc) ? i_x : i_acc;
                default: o_res = i_acc + i_x;
            endcase
        end
    end

endmodule

>>> dv/tb_matrix_axis_reduction.sv
// self-checking testbench for matrix_axis_reduction: directed and random matrices
// depends on mar_pkg and the matrix_axis_reduction rtl
`timescale 1ns / 1ps

module tb_matrix_axis_reduction;
    import mar_pkg::*;

    localparam int IDLE_PCT      = 28;
    localparam int SETTLE_CYCLES = 8;
    localparam int QUIET_LIMIT   = 4000;
    localparam int HOLD_CYCLES   = 300;
    localparam int RANDOM_ITEMS  = 440;

    typedef struct packed {
        logic signed [ACC_W-1:0] value;
        logic [ROW_W-1:0]        index;
        logic                    last_flag;
    } t_result;

    logic                     i_clk       = 1'b0;
    logic                     i_rst_n     = 1'b0;
    logic                     i_cfg_wr_en = 1'b0;
    logic [1:0]               i_cfg_index = '0;
    logic [CFG_W-1:0]         i_cfg_data  = '0;
    logic                     i_in_valid  = 1'b0;
    logic                     o_in_stall;
    logic signed [ELEM_W-1:0] i_element   = '0;
    logic                     o_out_valid;
    logic                     i_out_stall = 1'b0;
    logic signed [ACC_W-1:0]  o_reduced_value;
    logic [ROW_W-1:0]         o_result_index;
    logic                     o_last_result;

    // shadow registers and predictor state
    logic [1:0]              cfg_op   = OP_SUM;
    logic [1:0]              cfg_axis = AXIS_ALL;
    logic [CFG_W-1:0]        cfg_rows = 11'd1;
    logic [6:0]              cfg_cols = 7'd1;
    logic [ROW_W-1:0]        row_pos  = '0;
    logic [COL_W-1:0]        col_pos  = '0;
    logic signed [ACC_W-1:0] running_total = '0;
    logic signed [ACC_W-1:0] column_totals [64];

    logic signed [ELEM_W-1:0] element_feed [$];
    t_result                  reduction_queue [$];
    t_result                  oldest_result;

    bit elem_taken;
    bit result_taken;
    bit no_idle;
    bit hold_start;
    bit hold_taken;
    int hold_left;
    int quiet_cycles;
    int fail_count;

    matrix_axis_reduction u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_element       (i_element),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_reduced_value (o_reduced_value),
        .o_result_index  (o_result_index),
        .o_last_result   (o_last_result)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic int eff_rows();
        int r;
        r = (cfg_rows == 0) ? 1 : int'(cfg_rows);
        return (r > int'(ROW_LIM)) ? int'(ROW_LIM) : r;
    endfunction

    function automatic int eff_cols();
        int c;
        c = (cfg_cols == 0) ? 1 : int'(cfg_cols);
        return (c > MAX_COLUMNS_DEF) ? MAX_COLUMNS_DEF : c;
    endfunction

    function automatic logic signed [ACC_W-1:0] merge_value(
        input logic signed [ACC_W-1:0] acc,
        input logic signed [ACC_W-1:0] x
    );
        if (cfg_op == OP_MAX) begin
            return (x > acc) ? x : acc;
        end else if (cfg_op == OP_MIN) begin
            return (x < acc) ? x : acc;
        end
        return acc + x;
    endfunction

    function automatic void reduce_element(input logic signed [ELEM_W-1:0] elem);
        logic signed [ACC_W-1:0] x;
        int   rows;
        int   cols;
        int   c;
        logic row_end;
        logic mat_end;
        rows    = eff_rows();
        cols    = eff_cols();
        x       = {{(ACC_W-ELEM_W){elem[ELEM_W-1]}}, elem};
        row_end = (int'(col_pos) + 1 >= cols);
        mat_end = row_end && (int'(row_pos) + 1 >= rows);
        if (cfg_axis == AXIS_ROW) begin
            running_total = (col_pos == 0) ? x : merge_value(running_total, x);
            if (row_end) begin
                reduction_queue.push_back(t_result'{running_total, row_pos, mat_end});
            end
        end else if (cfg_axis == AXIS_COL) begin
            column_totals[col_pos] = (row_pos == 0) ? x
                                   : merge_value(column_totals[col_pos], x);
            if (mat_end) begin
                for (c = 0; c < cols; c++) begin
                    reduction_queue.push_back(t_result'{column_totals[c], ROW_W'(c),
                                                        c == cols - 1});
                end
            end
        end else begin
            running_total = (row_pos == 0 && col_pos == 0) ? x
                          : merge_value(running_total, x);
            if (mat_end) begin
                reduction_queue.push_back(t_result'{running_total, '0, 1'b1});
            end
        end
        if (mat_end) begin
            row_pos = '0;
            col_pos = '0;
        end else if (row_end) begin
            col_pos = '0;
            row_pos = row_pos + 1'b1;
        end else begin
            col_pos = col_pos + 1'b1;
        end
    endfunction

    function automatic logic signed [ELEM_W-1:0] random_element();
        case ($urandom_range(7))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2: return '0;
            3: return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    // acceptance, prediction, checking and watchdog on the rising edge
    always @(posedge i_clk) begin
        elem_taken   = i_rst_n && i_in_valid && !o_in_stall;
        result_taken = i_rst_n && o_out_valid && !i_out_stall;
        if (result_taken) begin
            if (reduction_queue.size() == 0) begin
                fail_count++;
                if (fail_count <= 10) begin
                    $display("unexpected result: value %h index %0d last %b",
                             o_reduced_value, o_result_index, o_last_result);
                end
            end else begin
                oldest_result = reduction_queue.pop_front();
                if (oldest_result.value !== o_reduced_value ||
                    oldest_result.index !== o_result_index ||
                    oldest_result.last_flag !== o_last_result) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display({"mismatch: exp value %h index %0d last %b, ",
                                  "got value %h index %0d last %b"},
                                 oldest_result.value, oldest_result.index,
                                 oldest_result.last_flag, o_reduced_value,
                                 o_result_index, o_last_result);
                    end
                end
            end
        end
        if (elem_taken) begin
            reduce_element(i_element);
        end
        if (!i_rst_n || elem_taken || result_taken) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("[matrix_axis_reduction] ERROR");
            $finish;
        end
    end

    // element driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || elem_taken) begin
            if (element_feed.size() > 0 &&
                (no_idle || $urandom_range(99) >= IDLE_PCT)) begin
                i_in_valid <= 1'b1;
                i_element  <= element_feed.pop_front();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // result receiver, with one long hold-off
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else if (hold_start && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left  = HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= no_idle ? 1'b0 : ($urandom_range(99) < IDLE_PCT);
        end
    end

    task automatic write_reg(input t_reg idx, input logic [CFG_W-1:0] val);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        case (idx)
            REG_OPERATION:    cfg_op   = val[1:0];
            REG_REDUCE_AXIS:  cfg_axis = val[1:0];
            REG_ROW_COUNT:    cfg_rows = val;
            REG_COLUMN_COUNT: cfg_cols = val[6:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic set_matrix(input logic [CFG_W-1:0] op, input logic [CFG_W-1:0] axis,
                              input logic [CFG_W-1:0] rows, input logic [CFG_W-1:0] cols);
        write_reg(REG_OPERATION, op);
        write_reg(REG_REDUCE_AXIS, axis);
        write_reg(REG_ROW_COUNT, rows);
        write_reg(REG_COLUMN_COUNT, cols);
    endtask

    task automatic wait_idle();
        while (element_feed.size() != 0 || i_in_valid || reduction_queue.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        int phase;
        int random_items;
        int matrices;
        int n;
        int i;
        logic [CFG_W-1:0] rows;
        logic [CFG_W-1:0] cols;

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset settings: whole-matrix sum of 1x1
        element_feed.push_back(32'sh7FFF_FFFF);
        element_feed.push_back(32'sh8000_0000);
        wait_idle();

        // unused operation and axis codes, zero counts
        set_matrix(11'd3, 11'd3, 11'd0, 11'd0);
        element_feed.push_back(-32'sd1);
        element_feed.push_back(32'sd1);
        wait_idle();

        set_matrix(CFG_W'(OP_MAX), CFG_W'(AXIS_ROW), 11'd2, 11'd3);
        element_feed.push_back(32'sh8000_0000);
        element_feed.push_back(32'sh7FFF_FFFF);
        element_feed.push_back('0);
        element_feed.push_back(-32'sd5);
        element_feed.push_back(-32'sd3);
        element_feed.push_back(-32'sd9);
        wait_idle();

        set_matrix(CFG_W'(OP_MIN), CFG_W'(AXIS_COL), 11'd2, 11'd2);
        element_feed.push_back(32'sh7FFF_FFFF);
        element_feed.push_back(32'sh8000_0000);
        element_feed.push_back(32'sh0001_0000);
        element_feed.push_back(-32'sh0001_0000);
        wait_idle();

        // column count shrinks and operation changes mid-row
        set_matrix(CFG_W'(OP_SUM), CFG_W'(AXIS_ROW), 11'd1, 11'd5);
        element_feed.push_back(32'sh7FFF_FFFF);
        element_feed.push_back(32'sh7FFF_FFFF);
        element_feed.push_back(32'sh0000_8000);
        wait_idle();
        write_reg(REG_OPERATION, CFG_W'(OP_MAX));
        write_reg(REG_COLUMN_COUNT, 11'd2);
        element_feed.push_back(-32'sd7);
        wait_idle();

        // row count shrinks mid-matrix
        set_matrix(CFG_W'(OP_MIN), CFG_W'(AXIS_ALL), 11'd3, 11'd2);
        element_feed.push_back(32'sd100);
        element_feed.push_back(-32'sd100);
        element_feed.push_back(32'sh8000_0000);
        wait_idle();
        write_reg(REG_ROW_COUNT, 11'd1);
        element_feed.push_back(32'sd4);
        wait_idle();

        phase        = 0;
        random_items = 0;
        while (random_items < RANDOM_ITEMS || phase <= 2) begin
            no_idle = (phase == 1);
            if (phase == 0) begin
                // receiver holds off while the input fills
                set_matrix(CFG_W'($urandom_range(3)), CFG_W'(AXIS_ROW), 11'd32, 11'd1);
                matrices   = 1;
                hold_start = 1'b1;
            end else if (phase == 1) begin
                set_matrix(CFG_W'($urandom_range(3)), CFG_W'($urandom_range(3)),
                           11'd8, 11'd8);
                matrices = 2;
            end else if (phase == 2) begin
                set_matrix(CFG_W'($urandom_range(3)), CFG_W'(AXIS_COL), 11'd2, 11'd64);
                matrices = 1;
            end else begin
                case ($urandom_range(9))
                    0: cols = 11'd0;
                    1: cols = 11'd64;
                    2: cols = 11'd127;
                    default: cols = CFG_W'($urandom_range(1, 8));
                endcase
                if (cols > 8) begin
                    rows     = CFG_W'($urandom_range(0, 2));
                    matrices = 1;
                end else begin
                    rows     = ($urandom_range(9) == 0) ? 11'd0
                             : CFG_W'($urandom_range(1, 6));
                    matrices = $urandom_range(1, 3);
                end
                set_matrix(CFG_W'($urandom_range(3)), CFG_W'($urandom_range(3)),
                           rows, cols);
            end
            n = matrices * eff_rows() * eff_cols();
            for (i = 0; i < n; i++) begin
                element_feed.push_back(random_element());
            end
            random_items += n;
            wait_idle();
            phase++;
        end

        if (fail_count == 0) begin
            $display("[matrix_axis_reduction] OK");
        end else begin
            $display("[matrix_axis_reduction] ERROR");
        end
        $finish;
    end

endmodule

>>> filelist.f
+incdir+src
src/mar_pkg.sv
src/mar_ram.sv
src/mar_combine.sv
src/matrix_axis_reduction.sv
dv/tb_matrix_axis_reduction.sv
